[hw/rtl/quadrature_pedal_speed_sensor_macros.svh]
// Assertion macros for the quadrature pedal speed sensor checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef QUADRATURE_PEDAL_SPEED_SENSOR_MACROS_SVH
`define QUADRATURE_PEDAL_SPEED_SENSOR_MACROS_SVH

// Same-cycle implication, off while in reset.
`define QPSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define QPSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checks the cycle after a reset edge.
`define QPSS_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qpss_pkg.sv]
// Shared types, constants and helper functions for the pedal speed sensor.
// No dependencies; used by every RTL module of the block.
package qpss_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned NUM_W     = 32;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned DEN_W     = SCALE_W + DELTA_W;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [SPEED_W-1:0] STOP_SPEED_BOUNDARY = 16'd100;

  // sensor_mode codes; any other code decodes as single phase
  localparam logic [1:0] MODE_DUAL_FWD = 2'd0;
  localparam logic [1:0] MODE_DUAL_BWD = 2'd1;

  // reset values of the configuration registers
  localparam logic [1:0]         RST_SENSOR_MODE = MODE_DUAL_FWD;
  localparam logic [NUM_W-1:0]   RST_NUMERATOR   = '0;
  localparam logic [SCALE_W-1:0] RST_EDGE_SCALE  = 24'd1;
  localparam logic [COUNT_W-1:0] RST_ENABLE_THR  = 16'd1;
  localparam logic [COUNT_W-1:0] RST_BACKPED_THR = 16'd1;
  localparam logic [DELTA_W-1:0] RST_SPEED_TO    = 16'd1000;
  localparam logic [DELTA_W-1:0] RST_STOP_TO_LO  = 16'd1000;
  localparam logic [DELTA_W-1:0] RST_STOP_TO_HI  = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_MODE = 3'd0,
    REG_NUMERATOR   = 3'd1,
    REG_EDGE_SCALE  = 3'd2,
    REG_ENABLE_THR  = 3'd3,
    REG_BACKPED_THR = 3'd4,
    REG_SPEED_TO    = 3'd5,
    REG_STOP_TO_LO  = 3'd6,
    REG_STOP_TO_HI  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               hit;
  } step_t;

  // phase = {B, A}
  function automatic dir_t quad_dir(input logic [1:0] prev, input logic [1:0] cur);
    dir_t d;
    unique case ({prev, cur})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: d = DIR_FWD;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: d = DIR_BWD;
      default:                            d = DIR_NONE;
    endcase
    return d;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt);
    return (cnt == '1) ? cnt : cnt + COUNT_W'(1);
  endfunction

  // increment, then clamp at the threshold once it is reached
  function automatic step_t step_to_thr(input logic [COUNT_W-1:0] cnt,
                                        input logic [COUNT_W-1:0] thr);
    step_t r;
    r.count = sat_inc(cnt);
    r.hit   = 1'b0;
    if (r.count >= thr) begin
      r.count = thr;
      r.hit   = 1'b1;
    end
    return r;
  endfunction

endpackage

[hw/rtl/quadrature_pedal_speed_sensor.sv]
// Pedal sensor front end: quadrature or single-phase decode, step counting, drive
// and backpedal flags, and speed = speed_numerator / (edge_scale * delta) in 0.1 km/h.
// A sample that does not recompute the speed goes from ST_IDLE to ST_DONE; one that does
// passes first through ST_MUL, the serial multiplier, and then ST_DIV, the serial divider.
// ST_DONE loads the output register when it is empty or not stalled. One sample is in work
// at a time; the next is accepted once the result is in the output register.
// Depends on qpss_pkg, qpss_mul and qpss_div.
module quadrature_pedal_speed_sensor #(
  parameter logic [qpss_pkg::SPEED_W-1:0] STOP_SPEED_BOUNDARY = qpss_pkg::STOP_SPEED_BOUNDARY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [qpss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qpss_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_phase_a,
  input  logic                            in_phase_b,
  input  logic [qpss_pkg::TIME_W-1:0]     in_time_ms,
  input  logic                            in_clear_backpedal,
  input  logic                            in_clear_stop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [qpss_pkg::SPEED_W-1:0]    out_speed_tenths,
  output logic                            out_speed_updated,
  output logic                            out_drive_enabled,
  output logic                            out_backpedal_seen,
  output logic                            out_pedal_stopped
);

  localparam int unsigned TIME_W  = qpss_pkg::TIME_W;
  localparam int unsigned DELTA_W = qpss_pkg::DELTA_W;
  localparam int unsigned COUNT_W = qpss_pkg::COUNT_W;
  localparam int unsigned SPEED_W = qpss_pkg::SPEED_W;

  // configuration
  logic [1:0]                    mode_r;
  logic [qpss_pkg::NUM_W-1:0]    num_r;
  logic [qpss_pkg::SCALE_W-1:0]  scale_r;
  logic [COUNT_W-1:0]            en_thr_r, bp_thr_r;
  logic [DELTA_W-1:0]            spd_to_r, stop_lo_r, stop_hi_r;

  // sensor state
  qpss_pkg::state_t              state_r, state_nxt;
  logic [1:0]                    prev_r, prev_nxt;
  logic [COUNT_W-1:0]            fwd_r, fwd_nxt, bwd_r, bwd_nxt;
  logic                          drive_r, drive_nxt, bp_r, bp_nxt, stop_r, stop_nxt;
  logic [TIME_W-1:0]             last_t_r, last_t_nxt;
  logic [SPEED_W-1:0]            speed_r, speed_nxt;
  logic                          upd_r, upd_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]            out_speed_r, out_speed_nxt;
  logic                          out_upd_r, out_upd_nxt;
  logic                          out_drive_r, out_drive_nxt;
  logic                          out_bp_r, out_bp_nxt;
  logic                          out_stop_r, out_stop_nxt;

  // decode
  logic [TIME_W-1:0]             delta;
  logic                          mode_single, mode_fwd;
  logic [1:0]                    cur;
  qpss_pkg::dir_t                dir;
  logic                          ph_change, step_ok, ready, zero_case, stop_hit;
  logic [COUNT_W-1:0]            bwd_cur;
  logic [SPEED_W-1:0]            spd_before;
  logic [DELTA_W-1:0]            stop_to;
  qpss_pkg::step_t               st;

  // serial units
  logic                          mul_start, mul_done, div_done;
  logic [qpss_pkg::DEN_W-1:0]    mul_prod;
  logic [SPEED_W-1:0]            div_quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= qpss_pkg::RST_SENSOR_MODE;
      num_r     <= qpss_pkg::RST_NUMERATOR;
      scale_r   <= qpss_pkg::RST_EDGE_SCALE;
      en_thr_r  <= qpss_pkg::RST_ENABLE_THR;
      bp_thr_r  <= qpss_pkg::RST_BACKPED_THR;
      spd_to_r  <= qpss_pkg::RST_SPEED_TO;
      stop_lo_r <= qpss_pkg::RST_STOP_TO_LO;
      stop_hi_r <= qpss_pkg::RST_STOP_TO_HI;
    end else if (cfg_wr_en) begin
      unique case (qpss_pkg::cfg_reg_t'(cfg_index))
        qpss_pkg::REG_SENSOR_MODE: mode_r    <= cfg_wdata[1:0];
        qpss_pkg::REG_NUMERATOR:   num_r     <= cfg_wdata[qpss_pkg::NUM_W-1:0];
        qpss_pkg::REG_EDGE_SCALE:  scale_r   <= cfg_wdata[qpss_pkg::SCALE_W-1:0];
        qpss_pkg::REG_ENABLE_THR:  en_thr_r  <= cfg_wdata[COUNT_W-1:0];
        qpss_pkg::REG_BACKPED_THR: bp_thr_r  <= cfg_wdata[COUNT_W-1:0];
        qpss_pkg::REG_SPEED_TO:    spd_to_r  <= cfg_wdata[DELTA_W-1:0];
        qpss_pkg::REG_STOP_TO_LO:  stop_lo_r <= cfg_wdata[DELTA_W-1:0];
        qpss_pkg::REG_STOP_TO_HI:  stop_hi_r <= cfg_wdata[DELTA_W-1:0];
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    fwd_nxt       = fwd_r;
    bwd_nxt       = bwd_r;
    drive_nxt     = drive_r;
    bp_nxt        = bp_r;
    stop_nxt      = stop_r;
    last_t_nxt    = last_t_r;
    speed_nxt     = speed_r;
    upd_nxt       = upd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_speed_nxt = out_speed_r;
    out_upd_nxt   = out_upd_r;
    out_drive_nxt = out_drive_r;
    out_bp_nxt    = out_bp_r;
    out_stop_nxt  = out_stop_r;
    mul_start     = 1'b0;

    delta       = in_time_ms - last_t_r;
    mode_fwd    = (mode_r == qpss_pkg::MODE_DUAL_FWD);
    mode_single = !mode_fwd && (mode_r != qpss_pkg::MODE_DUAL_BWD);
    cur         = {in_phase_b, in_phase_a};
    dir         = qpss_pkg::quad_dir(prev_r, cur);
    ph_change   = mode_single ? (in_phase_a != prev_r[0]) : (cur != prev_r);
    // a jump of both phases changes prev_r only
    step_ok     = ph_change && (mode_single || dir != qpss_pkg::DIR_NONE);
    bwd_cur     = in_clear_backpedal ? '0 : bwd_r;
    st          = '0;
    // a backward step zeroes the speed before the stop timeout is chosen
    spd_before  = (!mode_single && ph_change && dir == qpss_pkg::DIR_BWD) ? '0 : speed_r;
    ready       = 1'b0;

    // timeout compares, evaluated against the speed before this sample
    stop_to   = (spd_before > STOP_SPEED_BOUNDARY) ? stop_hi_r : stop_lo_r;
    zero_case = (delta == '0) || (delta >= {{(TIME_W-DELTA_W){1'b0}}, spd_to_r});
    stop_hit  = (delta >= {{(TIME_W-DELTA_W){1'b0}}, stop_to});

    unique case (state_r)
      qpss_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_clear_backpedal) begin
            bp_nxt  = 1'b0;
            bwd_nxt = '0;
          end
          if (in_clear_stop) begin
            stop_nxt = 1'b0;
          end
          if (step_ok) begin
            last_t_nxt = in_time_ms;
            stop_nxt   = 1'b0;
          end
          if (mode_single) begin
            if (ph_change) begin
              st       = qpss_pkg::step_to_thr(fwd_r, en_thr_r);
              fwd_nxt  = st.count;
              prev_nxt = {1'b0, in_phase_a};
              if (st.hit) begin
                drive_nxt = 1'b1;
              end
            end
          end else if (ph_change) begin
            prev_nxt = cur;
            if (dir == qpss_pkg::DIR_FWD) begin
              bwd_nxt = '0;
              if (mode_fwd) begin
                st      = qpss_pkg::step_to_thr(fwd_r, en_thr_r);
                fwd_nxt = st.count;
                bp_nxt  = 1'b0;
                if (st.hit) begin
                  drive_nxt = 1'b1;
                end
              end else begin
                fwd_nxt   = qpss_pkg::sat_inc(fwd_r);
                drive_nxt = 1'b0;
              end
            end else if (dir == qpss_pkg::DIR_BWD) begin
              fwd_nxt = '0;
              if (mode_fwd) begin
                st        = qpss_pkg::step_to_thr(bwd_cur, bp_thr_r);
                bwd_nxt   = st.count;
                drive_nxt = 1'b0;
                if (st.hit) begin
                  bp_nxt = 1'b1;
                end
              end else begin
                st      = qpss_pkg::step_to_thr(bwd_cur, en_thr_r);
                bwd_nxt = st.count;
                if (st.hit) begin
                  drive_nxt = 1'b1;
                end
              end
            end
          end

          ready = step_ok || (!ph_change && speed_r != '0 &&
                  delta >= {{(TIME_W-DELTA_W){1'b0}}, spd_to_r});
          upd_nxt   = ready;
          speed_nxt = spd_before;
          state_nxt = qpss_pkg::ST_DONE;
          if (ready) begin
            if (zero_case) begin
              speed_nxt = '0;
              if (stop_hit) begin
                stop_nxt = 1'b1;
              end
            end else if (scale_r == '0 || num_r == '0) begin
              speed_nxt = '0;
            end else begin
              mul_start = 1'b1;
              state_nxt = qpss_pkg::ST_MUL;
            end
          end
        end
      end
      qpss_pkg::ST_MUL: begin
        if (mul_done) begin
          state_nxt = qpss_pkg::ST_DIV;
        end
      end
      qpss_pkg::ST_DIV: begin
        if (div_done) begin
          speed_nxt = div_quot;
          state_nxt = qpss_pkg::ST_DONE;
        end
      end
      qpss_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = speed_r;
          out_upd_nxt   = upd_r;
          out_drive_nxt = drive_r;
          out_bp_nxt    = bp_r && mode_fwd;
          out_stop_nxt  = stop_r;
          state_nxt     = qpss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qpss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qpss_pkg::ST_IDLE;
      prev_r      <= '0;
      fwd_r       <= '0;
      bwd_r       <= '0;
      drive_r     <= 1'b0;
      bp_r        <= 1'b0;
      stop_r      <= 1'b0;
      last_t_r    <= '0;
      speed_r     <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      fwd_r       <= fwd_nxt;
      bwd_r       <= bwd_nxt;
      drive_r     <= drive_nxt;
      bp_r        <= bp_nxt;
      stop_r      <= stop_nxt;
      last_t_r    <= last_t_nxt;
      speed_r     <= speed_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_speed_r <= out_speed_nxt;
    out_upd_r   <= out_upd_nxt;
    out_drive_r <= out_drive_nxt;
    out_bp_r    <= out_bp_nxt;
    out_stop_r  <= out_stop_nxt;
  end

  // delta is below speed_timeout_ms here, so its low DELTA_W bits hold all of it
  qpss_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (scale_r),
    .mplier (delta[DELTA_W-1:0]),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  qpss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_done),
    .dividend (num_r),
    .divisor  (mul_prod),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign in_stall           = (state_r != qpss_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_speed_tenths   = out_speed_r;
  assign out_speed_updated  = out_upd_r;
  assign out_drive_enabled  = out_drive_r;
  assign out_backpedal_seen = out_bp_r;
  assign out_pedal_stopped  = out_stop_r;

endmodule

[hw/rtl/qpss_mul.sv]
// Bit-serial shift-add multiplier: edge_scale times elapsed ms.
// Depends on qpss_pkg. One multiplier bit per cycle.
module qpss_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qpss_pkg::SCALE_W-1:0]  mcand,
  input  logic [qpss_pkg::DELTA_W-1:0]  mplier,
  output logic                          done,
  output logic [qpss_pkg::DEN_W-1:0]    prod
);

  localparam int unsigned CNT_W = $clog2(qpss_pkg::DELTA_W);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [qpss_pkg::DEN_W-1:0]   p_r, p_nxt;
  logic [qpss_pkg::SCALE_W:0]   sum;

  always_comb begin
    sum      = {1'b0, p_r[qpss_pkg::DEN_W-1:qpss_pkg::DELTA_W]} +
               (p_r[0] ? {1'b0, mcand} : '0);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      p_nxt    = {{qpss_pkg::SCALE_W{1'b0}}, mplier};
    end else if (busy_r) begin
      // upper half accumulates, multiplier bits shift out at the bottom
      p_nxt   = {sum, p_r[qpss_pkg::DELTA_W-1:1]};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(qpss_pkg::DELTA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

[hw/rtl/qpss_div.sv]
// Radix-2 restoring divider with saturation to the speed width.
// Depends on qpss_pkg. One quotient bit per cycle.
module qpss_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qpss_pkg::NUM_W-1:0]    dividend,
  input  logic [qpss_pkg::DEN_W-1:0]    divisor,
  output logic                          done,
  output logic [qpss_pkg::SPEED_W-1:0]  quot
);

  localparam int unsigned CNT_W = $clog2(qpss_pkg::SPEED_W);
  localparam int unsigned HI_W  = qpss_pkg::NUM_W - qpss_pkg::SPEED_W;

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic                           sat_r, sat_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [qpss_pkg::DEN_W-1:0]     rem_r, rem_nxt;
  logic [qpss_pkg::SPEED_W-1:0]   nq_r, nq_nxt;
  logic [qpss_pkg::DEN_W-1:0]     hi_ext;
  logic [qpss_pkg::DEN_W:0]       shifted;
  logic [qpss_pkg::DEN_W+1:0]     diff;
  logic                           fits;

  always_comb begin
    hi_ext   = {{(qpss_pkg::DEN_W - HI_W){1'b0}},
                dividend[qpss_pkg::NUM_W-1:qpss_pkg::SPEED_W]};
    shifted  = {rem_r, nq_r[qpss_pkg::SPEED_W-1]};
    diff     = {1'b0, shifted} - {2'b00, divisor};
    fits     = !diff[qpss_pkg::DEN_W+1];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      // quotient overflows SPEED_W bits when the upper half alone reaches the divisor
      sat_nxt  = (hi_ext >= divisor);
      rem_nxt  = hi_ext;
      nq_nxt   = dividend[qpss_pkg::SPEED_W-1:0];
    end else if (busy_r) begin
      rem_nxt = fits ? diff[qpss_pkg::DEN_W-1:0] : shifted[qpss_pkg::DEN_W-1:0];
      nq_nxt  = {nq_r[qpss_pkg::SPEED_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(qpss_pkg::SPEED_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= sat_nxt;
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
  end

  assign done = done_r;
  assign quot = sat_r ? '1 : nq_r;

endmodule

[hw/rtl/qpss_checker.sv]
// Port-level checker for the pedal speed sensor, bound to the top level.
// Depends on quadrature_pedal_speed_sensor_macros.svh.
`include "quadrature_pedal_speed_sensor_macros.svh"

module qpss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [qpss_pkg::SPEED_W-1:0]    out_speed_tenths,
  input logic                            out_pedal_stopped
);

  `QPSS_ASSERT_RST(a_reset_idle, !out_valid && !in_stall, "qpss: not idle after reset")

  // one sample in work at a time
  `QPSS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "qpss: took two samples")

  // a stopped pedal never reports a speed
  `QPSS_ASSERT_IMP(a_stop_zero_speed, out_valid && out_pedal_stopped, out_speed_tenths == '0, "qpss: speed while stopped")

  `QPSS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_speed_tenths) && $stable(out_pedal_stopped), "qpss: stalled result changed")

endmodule

bind quadrature_pedal_speed_sensor qpss_checker u_qpss_checker (.*);
